// ===== sv/llss_pkg.sv =====
// ----------------------------------------------------------------------------
// llss_pkg
// Shared types and constants for the linear layer with saturating seed unit.
// ----------------------------------------------------------------------------
package llss_pkg;

	localparam int NUM_INPUTS  = 8;
	localparam int NUM_OUTPUTS = 8;

	localparam int WT_DEPTH = NUM_INPUTS * NUM_OUTPUTS;
	localparam int ADDR_W   = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
	localparam int CNT_W    = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

	localparam int WEIGHT_W = 16;
	localparam int SCORE_W  = 40;
	localparam int PROD_W   = 32;
	localparam int MAXW_W   = 15;

	// command queue between front and back, power-of-two depth
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = 1;
	localparam int CQ_CNT_W = 2;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_SEED  = 2'd1;
	localparam logic [1:0] KIND_ACT   = 2'd2;

	localparam logic [MAXW_W-1:0] MAXW_RESET = 15'h7fff;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_SEED,
		OP_ACT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		op_t                        op;
		logic [ADDR_W-1:0]          addr;
		logic signed [WEIGHT_W-1:0] value;
		logic signed [7:0]          amount;
		logic                       last;
		logic                       row_ok;
	} cmd_t;

endpackage

// ===== sv/llss_ram.sv =====
// ----------------------------------------------------------------------------
// llss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llss_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/llss_front.sv =====
// ----------------------------------------------------------------------------
// llss_front
// Accepts input items, drops the ones with no effect, queues commands.
// ----------------------------------------------------------------------------
module llss_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                kind,
	input  logic [2:0]                row,
	input  logic [2:0]                column,
	input  logic signed [15:0]        value,
	input  logic signed [7:0]         amount,
	input  logic                      last,
	output logic                      cmd_valid,
	output llss_pkg::cmd_t            cmd,
	input  logic                      cmd_take
);
	import llss_pkg::*;

	cmd_t                q_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;

	logic        accept;
	logic        keep;
	logic        row_ok;
	logic        col_ok;
	logic [31:0] addr_full;
	cmd_t        cmd_new;

	assign full      = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];

	assign row_ok = (32'(row) < 32'(NUM_INPUTS));
	assign col_ok = (32'(column) < 32'(NUM_OUTPUTS));

	// activate walks the whole row, so its base address has column zero
	assign addr_full = 32'(row) * 32'(NUM_OUTPUTS) +
		((kind == KIND_ACT) ? 32'd0 : 32'(column));

	always_comb begin
		cmd_new        = '0;
		cmd_new.addr   = addr_full[ADDR_W-1:0];
		cmd_new.value  = value;
		cmd_new.amount = amount;
		cmd_new.last   = last;
		cmd_new.row_ok = row_ok;
		keep           = 1'b0;
		case (kind)
			KIND_WRITE: begin
				cmd_new.op = OP_WRITE;
				keep       = row_ok && col_ok;
			end
			KIND_SEED: begin
				cmd_new.op = OP_SEED;
				keep       = row_ok && col_ok && (value != '0);
			end
			KIND_ACT: begin
				cmd_new.op = OP_ACT;
				// drop a plain activate that has no row to work on
				keep       = row_ok || last;
			end
			default: begin
				cmd_new.op = OP_WRITE;
				keep       = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			q_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if ((accept && keep) && !cmd_take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(accept && keep) && cmd_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/llss_back.sv =====
// ----------------------------------------------------------------------------
// llss_back
// Executes queued commands: weight table, multiply-accumulate, score output.
// ----------------------------------------------------------------------------
module llss_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  llss_pkg::cmd_t            cmd,
	output logic                      cmd_take,
	input  logic [llss_pkg::MAXW_W-1:0] clamp_limit_q,
	input  logic                      pop,
	output logic                      empty,
	output logic signed [39:0]        score,
	output logic [2:0]                output_index,
	output logic                      end_of_scores
);
	import llss_pkg::*;

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [CNT_W-1:0] cnt_q;
	logic        cnt_last;

	logic        ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WEIGHT_W-1:0] ram_wdata;
	logic        ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WEIGHT_W-1:0] ram_rdata;

	logic        issue;
	logic        emit;

	logic        v_s1;
	logic        v_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [SCORE_W-1:0] acc_q [NUM_OUTPUTS];
	logic signed [SCORE_W:0]   acc_sum;
	logic signed [SCORE_W-1:0] acc_sat;
	logic signed [SCORE_W-1:0] acc_in;
	logic        acc_shift;

	logic signed [17:0] seed_sum;
	logic signed [17:0] seed_lim;
	logic signed [17:0] seed_clamped;

	logic        out_valid_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [2:0]  index_q;
	logic        eos_q;

	assign cnt_last = (cnt_q == CNT_W'(NUM_OUTPUTS - 1));

	llss_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (WT_DEPTH),
		.ADDR_W(ADDR_W)
	) u_weights (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// seed: add whole units and clamp symmetrically
	always_comb begin
		seed_sum = 18'(signed'(ram_rdata)) + 18'(signed'({cmd_q.amount, 8'h00}));
		seed_lim = signed'({3'b000, clamp_limit_q});
		if (seed_sum > seed_lim) begin
			seed_clamped = seed_lim;
		end else if (seed_sum < -seed_lim) begin
			seed_clamped = -seed_lim;
		end else begin
			seed_clamped = seed_sum;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_SEED: state_d = ST_SEED;
						OP_ACT: begin
							if (cmd.row_ok) begin
								state_d = ST_MAC;
							end else if (cmd.last) begin
								state_d = ST_EMIT;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEED: state_d = ST_IDLE;
			ST_MAC: begin
				if (cnt_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = cmd_q.last ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit && cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_take  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cmd_q.addr;
		ram_wdata = seed_clamped[WEIGHT_W-1:0];
		ram_re    = 1'b0;
		ram_raddr = cmd.addr;
		issue     = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					case (cmd.op)
						OP_WRITE: begin
							ram_we    = 1'b1;
							ram_waddr = cmd.addr;
							ram_wdata = cmd.value;
						end
						OP_SEED: ram_re = 1'b1;
						default: ram_re = 1'b0;
					endcase
				end
			end
			ST_SEED: ram_we = 1'b1;
			ST_MAC: begin
				ram_re    = 1'b1;
				ram_raddr = cmd_q.addr + ADDR_W'(cnt_q);
				issue     = 1'b1;
			end
			ST_EMIT: emit = !out_valid_q || pop;
			default: issue = 1'b0;
		endcase
	end

	// accumulate the product, saturating to the score range
	assign acc_sum = 41'(acc_q[0]) + 41'(prod_s2);
	always_comb begin
		if (acc_sum[SCORE_W] != acc_sum[SCORE_W-1]) begin
			acc_sat = acc_sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
			                           : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[SCORE_W-1:0];
		end
	end

	// accumulators rotate: slot 0 is always the output being worked on
	assign acc_shift = v_s2 || emit;
	assign acc_in    = v_s2 ? acc_sat : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (acc_shift) begin
			for (int i = 0; i < NUM_OUTPUTS - 1; i++) begin
				acc_q[i] <= acc_q[i+1];
			end
			acc_q[NUM_OUTPUTS-1] <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (v_s1) begin
			prod_s2 <= PROD_W'(signed'(ram_rdata)) * PROD_W'(cmd_q.value);
		end
		if (emit) begin
			score_q <= acc_q[0];
			index_q <= 3'(cnt_q);
			eos_q   <= cnt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else if (issue || emit) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty         = !out_valid_q;
	assign score         = score_q;
	assign output_index  = index_q;
	assign end_of_scores = eos_q;

endmodule

// ===== sv/linear_layer_with_saturating_seed_unit.sv =====
// ----------------------------------------------------------------------------
// linear_layer_with_saturating_seed_unit
// Weight table with seeded updates and a matrix-vector product, Q24.16 scores.
// ----------------------------------------------------------------------------
// Back end: a weight write is done in the cycle it is taken, a seed reads
// the table, then clamps and writes back, and an activate is taken, runs one
// multiply-accumulate per output through the single table read port, then
// drains the read / multiply / accumulate pipeline. After a last activate
// the NUM_OUTPUTS scores follow at most one per cycle.
// Up to two commands queue ahead of the back end, so push stalls only then.
// Reset clears control, accumulators and the clamp limit (to 32767); the
// weight table is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module linear_layer_with_saturating_seed_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// input items
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 kind,
	input  logic [2:0]                 row,
	input  logic [2:0]                 column,
	input  logic signed [15:0]         value,
	input  logic signed [7:0]          amount,
	input  logic                       last,
	// scores
	input  logic                       pop,
	output logic                       empty,
	output logic signed [39:0]         score,
	output logic [2:0]                 output_index,
	output logic                       end_of_scores,
	// configuration
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [llss_pkg::MAXW_W-1:0] clamp_limit
);
	import llss_pkg::*;

	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_take;
	logic [MAXW_W-1:0] clamp_limit_q;

	// The clamp bound must be written only while idle, unchecked by the block, so take every transaction.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_limit_q <= MAXW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clamp_limit_q <= clamp_limit;
		end
	end

	// Front: accept every transaction while the queue has room, drop the ones that
	// change nothing (unused kind, out-of-range index, seed with a zero element),
	// and queue the rest with the table address already worked out.
	llss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.row      (row),
		.column   (column),
		.value    (value),
		.amount   (amount),
		.last     (last),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	// Back: one command at a time. Activates stream the row through a
	// read / multiply / accumulate pipeline; the accumulators rotate so the
	// adder always sees slot zero. Scores leave through an output register,
	// so the front keeps filling its queue while a score waits to be popped.
	llss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take),
		.clamp_limit_q(clamp_limit_q),
		.pop          (pop),
		.empty        (empty),
		.score        (score),
		.output_index (output_index),
		.end_of_scores(end_of_scores)
	);

endmodule

// ===== sv/llss_checker.sv =====
// ----------------------------------------------------------------------------
// llss_checker
// Port-level checks on the score queue, bound to the top level.
// ----------------------------------------------------------------------------
module llss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pop,
	input logic               empty,
	input logic signed [39:0] score,
	input logic [2:0]         output_index,
	input logic               end_of_scores
);
	import llss_pkg::*;

	// a waiting score stays until popped
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("score dropped before pop");

	// the last score of a vector carries the final output index
	a_eos_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_scores) |-> (output_index == 3'(NUM_OUTPUTS - 1)))
		else $error("end_of_scores on wrong output index");

	// a waiting score keeps its fields until popped
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(score) && $stable(output_index) &&
			$stable(end_of_scores)))
		else $error("score changed while waiting");

	// a fresh vector starts at output zero
	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		($past(empty) && !empty && $past(end_of_scores)) |-> (output_index == 3'd0))
		else $error("vector did not start at output zero");

endmodule

bind linear_layer_with_saturating_seed_unit llss_checker u_llss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pop          (pop),
	.empty        (empty),
	.score        (score),
	.output_index (output_index),
	.end_of_scores(end_of_scores)
);

// ===== tb/sv/tb_linear_layer_with_saturating_seed_unit.sv =====
// ----------------------------------------------------------------------------
// tb_linear_layer_with_saturating_seed_unit
// Self-checking bench for the weight table, seeded updates and scores.
// Drives weight writes, seeds, activates and unused-kind items through the
// push/full queue port, predicts every score and compares each popped score
// field by field. Covers table loading, corner items, several clamp bound
// settings and random vector traffic, with random idle gaps on both the item
// and the score side.
// ----------------------------------------------------------------------------
module tb_linear_layer_with_saturating_seed_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import llss_pkg::*;

	// kind 3 has no meaning in the block; it must be swallowed silently
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam longint ACC_MAX = (longint'(1) <<< (SCORE_W - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	// Cycles the back end may still be busy after the last score: two queued
	// commands plus an activate in flight, then the score emission.
	localparam int SETTLE_CYCLES = 4 * (NUM_OUTPUTS + 4) + NUM_OUTPUTS;
	localparam int STALL_LIMIT   = 2000;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_ITEMS  = 40;

	typedef struct {
		logic [1:0]                 kind;
		logic [2:0]                 row;
		logic [2:0]                 column;
		logic signed [WEIGHT_W-1:0] value;
		logic signed [7:0]          amount;
		logic                       last;
	} item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [2:0]                out_idx;
		logic                      eos;
	} score_t;

	// ------------------------------------------------------------------------
	// Clock, reset and block ports
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                       push   = 1'b0;
	logic                       full;
	logic [1:0]                 kind   = KIND_WRITE;
	logic [2:0]                 row    = '0;
	logic [2:0]                 column = '0;
	logic signed [WEIGHT_W-1:0] value  = '0;
	logic signed [7:0]          amount = '0;
	logic                       last   = 1'b0;

	logic                       pop = 1'b0;
	logic                       empty;
	logic signed [SCORE_W-1:0]  score;
	logic [2:0]                 output_index;
	logic                       end_of_scores;

	logic                       cfg_valid   = 1'b0;
	logic                       cfg_ready;
	logic [MAXW_W-1:0]          clamp_limit = MAXW_RESET;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	linear_layer_with_saturating_seed_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.kind          (kind),
		.row           (row),
		.column        (column),
		.value         (value),
		.amount        (amount),
		.last          (last),
		.pop           (pop),
		.empty         (empty),
		.score         (score),
		.output_index  (output_index),
		.end_of_scores (end_of_scores),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.clamp_limit   (clamp_limit)
	);

	// ------------------------------------------------------------------------
	// Layer model: weight table, accumulators and clamp bound as the block
	// should hold them, plus the scores still owed by the block.
	// ------------------------------------------------------------------------
	logic signed [WEIGHT_W-1:0] weights [NUM_INPUTS][NUM_OUTPUTS];
	longint                     accums  [NUM_OUTPUTS];
	logic [MAXW_W-1:0]          clamp_bound = MAXW_RESET;
	score_t                     pending_scores[$];

	int  mismatches   = 0;
	int  quiet_cycles = 0;
	int  pop_hold     = 0;
	bit  tx_steady    = 1'b0;
	bit  rx_steady    = 1'b0;

	initial begin
		foreach (accums[j])
			accums[j] = 0;
	end

	// Apply one accepted item to the model; queue the scores it releases.
	function automatic void update_layer_model(input item_t it);
		int     sum;
		int     lim;
		longint nxt;
		score_t s;
		case (it.kind)
			KIND_WRITE: begin
				if (it.row < NUM_INPUTS && it.column < NUM_OUTPUTS)
					weights[it.row][it.column] = it.value;
			end
			KIND_SEED: begin
				// a zero element leaves the weight alone; otherwise add whole
				// units and clamp, even when the old weight was out of bounds
				if (it.row < NUM_INPUTS && it.column < NUM_OUTPUTS && it.value != 0) begin
					lim = int'(clamp_bound);
					sum = int'(weights[it.row][it.column]) + int'(it.amount) * 256;
					if (sum > lim)
						sum = lim;
					if (sum < -lim)
						sum = -lim;
					weights[it.row][it.column] = sum[WEIGHT_W-1:0];
				end
			end
			KIND_ACT: begin
				if (it.row < NUM_INPUTS) begin
					for (int j = 0; j < NUM_OUTPUTS; j++) begin
						nxt = accums[j] + longint'(weights[it.row][j]) * longint'(it.value);
						if (nxt > ACC_MAX)
							nxt = ACC_MAX;
						if (nxt < ACC_MIN)
							nxt = ACC_MIN;
						accums[j] = nxt;
					end
				end
				// a last mark releases every score and clears the vector
				if (it.last) begin
					for (int j = 0; j < NUM_OUTPUTS; j++) begin
						s.score   = accums[j][SCORE_W-1:0];
						s.out_idx = j[2:0];
						s.eos     = (j == NUM_OUTPUTS - 1);
						pending_scores.push_back(s);
						accums[j] = 0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Idle length: mostly short, sometimes medium, rarely long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t make_item(input logic [1:0] k, input int r, input int c,
			input logic signed [WEIGHT_W-1:0] v, input logic signed [7:0] a, input logic l);
		item_t it;
		it.kind   = k;
		it.row    = r[2:0];
		it.column = c[2:0];
		it.value  = v;
		it.amount = a;
		it.last   = l;
		return it;
	endfunction

	// Random item of the given kind; every field random, values biased to the rails.
	function automatic item_t rand_item(input logic [1:0] k);
		item_t it;
		int    pick;
		it   = make_item(k, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom),
			8'($urandom), 1'($urandom_range(0, 1)));
		pick = $urandom_range(0, 15);
		case (pick)
			0: it.value = 16'sh7fff;
			1: it.value = 16'sh8000;
			2: it.value = 16'sh0000;
			3: it.value = 16'shffff;
			default: ;
		endcase
		return it;
	endfunction

	// Present one item and hold it until the block takes the transaction.
	// Push stays high afterwards so back-to-back items need no idle gap between them.
	task automatic send_item(input item_t it);
		kind   <= it.kind;
		row    <= it.row;
		column <= it.column;
		value  <= it.value;
		amount <= it.amount;
		last   <= it.last;
		push   <= 1'b1;
		do
			@(posedge clk);
		while (full !== 1'b0);
		update_layer_model(it);
	endtask

	// Send with an optional random idle gap in front.
	task automatic pace_send(input item_t it);
		int n;
		if (!tx_steady && $urandom_range(0, 2) == 0) begin
			n = gap_len();
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
		send_item(it);
	endtask

	// Drain every owed score, then let the back end finish silent commands.
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write on the config channel, only with the block idle.
	task automatic write_clamp_limit(input logic [MAXW_W-1:0] bound);
		wait_idle();
		clamp_limit <= bound;
		cfg_valid   <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid   <= 1'b0;
		clamp_bound  = bound;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Fill the whole table first so no later item reads an unwritten weight.
	task automatic test_table_load();
		logic signed [WEIGHT_W-1:0] v;
		for (int r = 0; r < NUM_INPUTS; r++) begin
			for (int c = 0; c < NUM_OUTPUTS; c++) begin
				v = 16'($urandom);
				if (r == c)
					v = (r[0]) ? 16'sh8000 : 16'sh7fff;
				pace_send(make_item(KIND_WRITE, r, c, v, 8'($urandom),
					1'($urandom_range(0, 1))));
			end
		end
	endtask

	// Rails, both clamp directions, zero-element seed, ignored kind and last
	// marks on items that must not release scores.
	task automatic test_directed_corners();
		pace_send(make_item(KIND_WRITE, 0, 0, 16'sh7fff, 8'sh00, 1'b0));
		pace_send(make_item(KIND_WRITE, 0, 1, 16'sh8000, 8'sh00, 1'b0));
		pace_send(make_item(KIND_WRITE, 0, 2, 16'sh0000, 8'sh00, 1'b0));
		// push past the top, then past the bottom of the default bound
		pace_send(make_item(KIND_SEED, 0, 0, 16'sh0005, 8'sh7f, 1'b0));
		pace_send(make_item(KIND_SEED, 0, 1, 16'shffff, 8'sh80, 1'b0));
		// zero element: weight must not move
		pace_send(make_item(KIND_SEED, 0, 2, 16'sh0000, 8'sh64, 1'b1));
		pace_send(make_item(KIND_SEED, 0, 3, 16'sh8000, 8'sh01, 1'b0));
		// unused kind with last set: no scores
		pace_send(make_item(KIND_UNUSED, 7, 7, 16'sh7fff, 8'sh7f, 1'b1));
		pace_send(make_item(KIND_WRITE, 7, 7, 16'sh0100, 8'shff, 1'b1));
		pace_send(make_item(KIND_ACT, 0, 7, 16'sh7fff, 8'sh00, 1'b0));
		pace_send(make_item(KIND_ACT, 0, 0, 16'sh8000, 8'sh00, 1'b0));
		pace_send(make_item(KIND_ACT, 7, 0, 16'sh0000, 8'sh00, 1'b0));
		pace_send(make_item(KIND_ACT, 7, 5, 16'sh0100, 8'sh00, 1'b1));
		// one-element vector, then a vector whose element is zero
		pace_send(make_item(KIND_ACT, 3, 0, 16'shffff, 8'sh7f, 1'b1));
		pace_send(make_item(KIND_ACT, 5, 2, 16'sh0000, 8'sh80, 1'b1));
	endtask

	// Sweep the clamp bound over its extremes and a few points between; seed
	// row 1, including weights already outside the bound, and read it back
	// by activating with 1.0.
	task automatic test_clamp_bound();
		logic [MAXW_W-1:0]          bounds [5];
		logic signed [WEIGHT_W-1:0] v;
		bounds[0] = '0;
		bounds[1] = 15'd1;
		bounds[2] = 15'd256;
		bounds[3] = 15'($urandom);
		bounds[4] = MAXW_RESET;
		foreach (bounds[b]) begin
			write_clamp_limit(bounds[b]);
			pace_send(make_item(KIND_WRITE, 1, 0, 16'sh7fff, 8'($urandom),
				1'($urandom_range(0, 1))));
			pace_send(make_item(KIND_WRITE, 1, 1, 16'sh8000, 8'($urandom),
				1'($urandom_range(0, 1))));
			for (int c = 0; c < NUM_OUTPUTS; c++) begin
				v = 16'($urandom);
				if (v == 0)
					v = 16'sh0001;
				// zero amount on the first two columns: clamp alone
				pace_send(make_item(KIND_SEED, 1, c, v, (c < 2) ? 8'sh00 : 8'($urandom),
					1'($urandom_range(0, 1))));
			end
			pace_send(make_item(KIND_ACT, 1, 0, 16'sh0100, 8'sh00, 1'b1));
		end
	endtask

	// Mostly well-formed vectors with writes and seeds mixed in, a little
	// unused-kind noise and now and then a vector left open into the next.
	task automatic test_random_traffic();
		item_t it;
		int    sent;
		int    len;
		int    pick;
		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			pick = $urandom_range(0, 3);
			write_clamp_limit((pick == 0) ? 15'd0 : (pick == 1) ? MAXW_RESET : 15'($urandom));
			while (sent < (phase + 1) * RANDOM_ITEMS / 4) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 3) == 0) begin
						pace_send(rand_item($urandom_range(0, 1) ? KIND_WRITE : KIND_SEED));
						sent++;
					end
					if ($urandom_range(0, 29) == 0)
						pace_send(rand_item(KIND_UNUSED));
					it      = rand_item(KIND_ACT);
					it.last = (i == len - 1) && ($urandom_range(0, 9) != 0);
					pace_send(it);
					sent++;
				end
			end
		end
		// close any vector still open so its scores are checked too
		pace_send(make_item(KIND_ACT, $urandom_range(0, 7), 0, 16'($urandom), 8'sh00, 1'b1));
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Score side: random pop stalls, then check each popped transaction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop      <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else begin
			pop <= 1'b1;
			if (!rx_steady && $urandom_range(0, 3) == 0)
				pop_hold <= gap_len();
		end
	end

	always @(posedge clk) begin
		score_t got;
		score_t want;
		if (arst_n && pop && !empty) begin
			got = '{score, output_index, end_of_scores};
			if (pending_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected score %0d index %0d end %0b", $realtime,
						got.score, got.out_idx, got.eos);
			end else begin
				want = pending_scores.pop_front();
				if (got.score !== want.score || got.out_idx !== want.out_idx ||
						got.eos !== want.eos) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t mismatch: exp %0d idx %0d end %0b, got %0d idx %0d end %0b",
							$realtime, want.score, want.out_idx, want.eos,
							got.score, got.out_idx, got.eos);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: abort when no transaction moves on any port for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("** linear_layer_with_saturating_seed_unit: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_directed_corners();
		test_clamp_bound();
		test_random_traffic();

		// drain, then give the block time to show anything it should not
		push <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_scores.size() == 0)
			$display("** linear_layer_with_saturating_seed_unit: PASSED **");
		else
			$display("** linear_layer_with_saturating_seed_unit: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/llss_pkg.sv
sv/llss_ram.sv
sv/llss_front.sv
sv/llss_back.sv
sv/linear_layer_with_saturating_seed_unit.sv
sv/llss_checker.sv
tb/sv/tb_linear_layer_with_saturating_seed_unit.sv
